FILE: rtl/fca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the chain allocator: table geometry, entry
// codes, status codes, sequencer states and the request and result records.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int BLOCKS      = 4096;
    localparam int ADDR_W      = $clog2(BLOCKS);
    localparam int ENTRY_W     = ADDR_W + 1;
    localparam int BLOCK_BYTES = 512;
    localparam int BLK_W       = 12;
    localparam int BYTES_W     = 10;
    localparam int SIZE_W      = 22;
    localparam int COUNT_W     = 13;

    // Entry codes: zero is free, the top bit alone is the end marker,
    // anything else holds the next block of the chain.
    localparam logic [ENTRY_W-1:0] ENTRY_FREE = '0;
    localparam logic [ENTRY_W-1:0] ENTRY_END  = ENTRY_W'(BLOCKS);

    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(BLOCKS - 1);
    localparam logic [SIZE_W-1:0]  SIZE_MAX   = '1;

    typedef enum logic [1:0] {
        STAT_ALLOC = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_FREED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_MARK,
        S_WALK_RD,
        S_WALK_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               mode;
        logic               first_chunk;
        logic               last_chunk;
        logic [BYTES_W-1:0] chunk_bytes;
        logic [BLK_W-1:0]   start_block;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic [BLK_W-1:0]   block_index;
        logic [BLK_W-1:0]   file_first_block;
        logic [SIZE_W-1:0]  file_bytes;
        logic [COUNT_W-1:0] freed_count;
    } t_result;

endpackage

FILE: rtl/fca_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_table_ram
// Simple dual-port RAM for the link table: one write port, one read port
// with registered read data.
// ----------------------------------------------------------------------------
module fca_table_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 13,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fca_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_seq
// Sequencer of the allocator: clears the table after reset, scans for the
// lowest free entry, links and marks new blocks, and walks chains to free.
// ----------------------------------------------------------------------------
module fca_seq
    import fca_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_request i_req,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_res
);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic               r_chk_v, n_chk_v;
    logic [ADDR_W-1:0]  r_chk_addr, n_chk_addr;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0]  r_prev, n_prev;
    logic [ADDR_W-1:0]  r_first, n_first;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_newfile, n_newfile;
    t_request           r_req, n_req;
    t_result            r_res, n_res;

    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;

    logic [SIZE_W-1:0]  size_base;
    logic [SIZE_W-1:0]  chunk_clamp;
    logic [SIZE_W:0]    size_sum;
    logic [COUNT_W-1:0] count_inc;
    logic [ADDR_W-1:0]  link;

    fca_table_ram #(
        .DEPTH  (BLOCKS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_chk_v <= 1'b0;
            r_prev  <= '0;
            r_first <= '0;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_chk_v <= n_chk_v;
            r_prev  <= n_prev;
            r_first <= n_first;
            r_size  <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_idx      <= n_idx;
        r_count    <= n_count;
        r_newfile  <= n_newfile;
        r_req      <= n_req;
        r_res      <= n_res;
    end

    assign chunk_clamp = (int'(r_req.chunk_bytes) > BLOCK_BYTES) ?
                         SIZE_W'(BLOCK_BYTES) : SIZE_W'(r_req.chunk_bytes);
    assign size_base   = r_newfile ? '0 : r_size;
    assign size_sum    = {1'b0, size_base} + {1'b0, chunk_clamp};
    assign count_inc   = r_count + 1'b1;
    assign link        = rdata[ADDR_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_chk_v    = r_chk_v;
        n_chk_addr = r_chk_addr;
        n_idx      = r_idx;
        n_prev     = r_prev;
        n_first    = r_first;
        n_size     = r_size;
        n_count    = r_count;
        n_newfile  = r_newfile;
        n_req      = r_req;
        n_res      = r_res;
        we         = 1'b0;
        waddr      = r_ptr;
        wdata      = ENTRY_FREE;
        re         = 1'b0;
        raddr      = r_ptr;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wdata = (r_ptr == '0) ? ENTRY_END : ENTRY_FREE;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_newfile = i_req.first_chunk || (r_prev == '0);
                    n_count   = '0;
                    n_chk_v   = 1'b0;
                    if (i_req.mode) begin
                        if (i_req.start_block == '0 || int'(i_req.start_block) >= BLOCKS) begin
                            n_res = '{status: STAT_FREED, default: '0};
                            n_state = S_DONE;
                        end else begin
                            n_ptr   = ADDR_W'(i_req.start_block);
                            n_state = S_WALK_RD;
                        end
                    end else begin
                        n_ptr   = ADDR_W'(1);
                        n_state = S_SCAN;
                    end
                end
            end

            // Read one entry a cycle; check the entry that the previous cycle read.
            S_SCAN: begin
                re         = 1'b1;
                n_ptr      = r_ptr + 1'b1;
                n_chk_v    = 1'b1;
                n_chk_addr = r_ptr;
                if (r_chk_v) begin
                    if (rdata == ENTRY_FREE) begin
                        n_idx   = r_chk_addr;
                        n_state = S_LINK;
                    end else if (r_chk_addr == LAST_ADDR) begin
                        n_res.status           = STAT_FULL;
                        n_res.block_index      = '0;
                        n_res.file_first_block = r_newfile ? '0 : BLK_W'(r_first);
                        n_res.file_bytes       = r_newfile ? '0 : r_size;
                        n_res.freed_count      = '0;
                        n_state                = S_DONE;
                    end
                end
            end

            S_LINK: begin
                if (!r_newfile) begin
                    we    = 1'b1;
                    waddr = r_prev;
                    wdata = {1'b0, r_idx};
                end
                n_state = S_MARK;
            end

            S_MARK: begin
                we      = 1'b1;
                waddr   = r_idx;
                wdata   = ENTRY_END;
                n_size  = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
                n_first = r_newfile ? r_idx : r_first;
                n_prev  = r_req.last_chunk ? '0 : r_idx;
                n_res.status           = STAT_ALLOC;
                n_res.block_index      = BLK_W'(r_idx);
                n_res.file_first_block = BLK_W'(n_first);
                n_res.file_bytes       = n_size;
                n_res.freed_count      = '0;
                n_state                = S_DONE;
            end

            S_WALK_RD: begin
                re      = 1'b1;
                n_state = S_WALK_CHK;
            end

            S_WALK_CHK: begin
                if (rdata == ENTRY_FREE) begin
                    n_res   = '{status: STAT_FREED, freed_count: r_count, default: '0};
                    n_state = S_DONE;
                end else begin
                    we      = 1'b1;
                    n_count = count_inc;
                    // close the open file when its tail block goes away
                    if (r_ptr == r_prev) begin
                        n_prev = '0;
                    end
                    // a self link would read the entry being cleared: stop here
                    if (rdata[ADDR_W] || link == '0 || link == r_ptr) begin
                        n_res   = '{status: STAT_FREED, freed_count: count_inc, default: '0};
                        n_state = S_DONE;
                    end else begin
                        re    = 1'b1;
                        raddr = link;
                        n_ptr = link;
                    end
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_mark_not_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_idx != '0))
        else $error("allocated block is the reserved entry");

    a_full_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_res.status == STAT_FULL) |-> (r_res.block_index == '0))
        else $error("table-full result carries a block");

    a_freed_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_CHK) |-> (int'(r_count) < BLOCKS))
        else $error("chain walk exceeded table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while previous one still in work");
`endif

endmodule

FILE: rtl/fat_chain_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_block_allocator_unit
// Allocation-table chain allocator: appends blocks to a file and frees chains.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects append or free and
//   flags a new file, tlast marks the last chunk of a file, tdata carries the
//   chunk size and the start block of a chain to free. Every request gives
//   exactly one result on m_axis: status in tuser, block, first block, file
//   size and freed count in tdata.
//   After reset the table is cleared one entry per cycle with s_axis_tready
//   low; then entry 0 holds the end marker and all others are free.
//   An append scans upward from entry 1 for the lowest free entry, links it
//   behind the open file and marks it as the end; with no free entry it gives
//   a full status. A free walks the chain and clears each entry, stops on the
//   end marker or a free entry, and answers a reserved start without a walk.
//   Scan and walk are set by the single table read port, one entry per cycle.
//   One request is in work at a time; the next is taken once the result has
//   been handed to the output register.
//   A stalled m_axis holds its result in the output register; a further
//   result waits inside the sequencer until the register drains.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator_unit
    import fca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chunk_bytes[9:0], start_block[21:10], zero fill
    input  logic [1:0]  s_axis_tuser,   // mode[0], first_chunk[1]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // block_index[11:0], file_first_block[23:12],
                                        // file_bytes[45:24], freed_count[58:46], zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    t_request req;
    t_result  res;
    logic     res_valid;
    logic     res_take;
    logic     r_ov;
    t_result  r_out;

    assign req.mode        = s_axis_tuser[0];
    assign req.first_chunk = s_axis_tuser[1];
    assign req.last_chunk  = s_axis_tlast;
    assign req.chunk_bytes = s_axis_tdata[BYTES_W-1:0];
    assign req.start_block = s_axis_tdata[BYTES_W+BLK_W-1:BYTES_W];

    fca_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_take),
        .o_res       (res)
    );

    assign res_take = !r_ov || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_take) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {5'b0, r_out.freed_count, r_out.file_bytes,
                            r_out.file_first_block, r_out.block_index};

endmodule
